// File: hw/rtl/msdig_pkg.sv
// ----------------------------------------------------------------------------
// msdig_pkg: shared types and constants
// Source codes, configuration codes and register map of the diagonal band
// index generator.
// ----------------------------------------------------------------------------
package msdig_pkg;

  // config port address width: 8 registers at 4-byte spacing
  localparam int ADDR_W = 5;
  localparam int POS_W  = 32;
  // signed width for offsets, lengths and band arithmetic
  localparam int SGN_W  = 20;
  // accept edge to result edge
  localparam int PIPE_LAT = 70;

  typedef enum logic [1:0] {
    SRC_INPUT = 2'd0,
    SRC_BCAST = 2'd1,
    SRC_DIAG  = 2'd2,
    SRC_ZERO  = 2'd3
  } src_t;

  localparam logic [1:0] FILL_INPUT = 2'd0;
  localparam logic [1:0] FILL_BCAST = 2'd1;

  localparam logic [1:0] ALIGN_LR = 2'd0;
  localparam logic [1:0] ALIGN_RL = 2'd1;
  localparam logic [1:0] ALIGN_RR = 2'd3;

  localparam logic [2:0] REG_LOWEST  = 3'd0;
  localparam logic [2:0] REG_HIGHEST = 3'd1;
  localparam logic [2:0] REG_ROWS    = 3'd2;
  localparam logic [2:0] REG_COLS    = 3'd3;
  localparam logic [2:0] REG_COUNT   = 3'd4;
  localparam logic [2:0] REG_FILL    = 3'd5;
  localparam logic [2:0] REG_PRESENT = 3'd6;
  localparam logic [2:0] REG_ALIGN   = 3'd7;

endpackage

// File: hw/rtl/matrix_set_diag_index_gen_top.sv
// ----------------------------------------------------------------------------
// matrix_set_diag_index_gen_top: diagonal band source index generator
// Maps a flat element position of a batch of matrices to its data source.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a position beat is taken at each rising edge with start high and
//   busy low. busy stays low, so one position may enter every cycle.
//   Output: each result shows on out_* for one cycle with out_strobe high;
//   the receiver has no backpressure. Positions at or beyond element_count,
//   or with zero rows or cols, give no result and leave no gap in order.
//   Pipeline: input register, two 32-stage dividers for column and row,
//   five band arithmetic stages. Throughput: one result per cycle.
//   Configuration: APB-style, register i at byte 4*i, pready always high;
//   write only while no beats are in flight.
//   Reset: rst_n low clears all valid bits and loads register defaults; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module matrix_set_diag_index_gen_top #(
  parameter int INDEX_BITS = 32,
  parameter int DIM_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msdig_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 in_position,
  output logic                        out_strobe,
  output logic [31:0]                 out_write_index,
  output logic [1:0]                  out_source,
  output logic [31:0]                 out_source_index
);

  localparam int IW = (INDEX_BITS < 32) ? INDEX_BITS : 32;
  localparam int DW = (DIM_BITS < 16) ? DIM_BITS : 16;
  localparam int BW = msdig_pkg::SGN_W;
  localparam int EW = (IW > BW) ? IW : BW;
  localparam int PW = msdig_pkg::POS_W;

  function automatic logic [IW-1:0] to_iw(input logic signed [BW-1:0] v);
    logic signed [EW-1:0] w;
    w = EW'(v);
    return w[IW-1:0];
  endfunction

  // config registers
  logic signed [16:0] lowest_r;
  logic signed [16:0] highest_r;
  logic [DW-1:0]      rows_r;
  logic [DW-1:0]      cols_r;
  logic [31:0]        count_r;
  logic [1:0]         fill_r;
  logic               present_r;
  logic [1:0]         align_r;
  logic               cfg_wr;
  logic [2:0]         reg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = paddr[msdig_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r  <= '0;
      highest_r <= '0;
      rows_r    <= DW'(1);
      cols_r    <= DW'(1);
      count_r   <= '0;
      fill_r    <= '0;
      present_r <= 1'b1;
      align_r   <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        msdig_pkg::REG_LOWEST:  lowest_r  <= pwdata[16:0];
        msdig_pkg::REG_HIGHEST: highest_r <= pwdata[16:0];
        msdig_pkg::REG_ROWS:    rows_r    <= pwdata[DW-1:0];
        msdig_pkg::REG_COLS:    cols_r    <= pwdata[DW-1:0];
        msdig_pkg::REG_COUNT:   count_r   <= pwdata;
        msdig_pkg::REG_FILL:    fill_r    <= pwdata[1:0];
        msdig_pkg::REG_PRESENT: present_r <= pwdata[0];
        msdig_pkg::REG_ALIGN:   align_r   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      msdig_pkg::REG_LOWEST:  prdata = {{15{lowest_r[16]}}, lowest_r};
      msdig_pkg::REG_HIGHEST: prdata = {{15{highest_r[16]}}, highest_r};
      msdig_pkg::REG_ROWS:    prdata = 32'(rows_r);
      msdig_pkg::REG_COLS:    prdata = 32'(cols_r);
      msdig_pkg::REG_COUNT:   prdata = count_r;
      msdig_pkg::REG_FILL:    prdata = 32'(fill_r);
      msdig_pkg::REG_PRESENT: prdata = 32'(present_r);
      msdig_pkg::REG_ALIGN:   prdata = 32'(align_r);
      default:                prdata = '0;
    endcase
  end

  // band constants, re-registered every cycle
  logic signed [BW-1:0] k0_s, k1_s, mm_s, nn_s;
  logic signed [BW-1:0] k0p_s, k1n_s, k1p_s, ml_a, ml_b;
  logic signed [BW-1:0] mdl_r, nd_r, k1p_r;
  logic                 single_r;

  assign k0_s  = BW'(lowest_r);
  assign k1_s  = BW'(highest_r);
  assign mm_s  = signed'(BW'(rows_r));
  assign nn_s  = signed'(BW'(cols_r));
  assign k0p_s = (k0_s > 0) ? k0_s : '0;
  assign k1n_s = (k1_s < 0) ? k1_s : '0;
  assign k1p_s = (k1_s > 0) ? k1_s : '0;
  assign ml_a  = mm_s + k1n_s;
  assign ml_b  = nn_s - k0p_s;

  always_ff @(posedge clk) begin
    mdl_r    <= (ml_a < ml_b) ? ml_a : ml_b;
    nd_r     <= k1_s - k0_s + BW'(1);
    k1p_r    <= k1p_s;
    single_r <= (lowest_r == highest_r);
  end

  // input register
  logic          s0_vld_r;
  logic [PW-1:0] s0_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy & (in_position < count_r) &
                  (rows_r != '0) & (cols_r != '0);
    end
    s0_pos_r <= in_position;
  end

  // pos / cols, then (pos / cols) / rows
  logic             v1;
  logic [PW-1:0]    q1, pos1;
  logic [DW-1:0]    n1;
  logic             v2;
  logic [PW-1:0]    batch2, pos2;
  logic [DW-1:0]    m2, n2;

  msdig_div #(.NW(PW), .DW(DW), .SW(PW)) u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s0_vld_r),
    .in_num   (s0_pos_r),
    .den      (cols_r),
    .in_side  (s0_pos_r),
    .out_valid(v1),
    .out_quo  (q1),
    .out_rem  (n1),
    .out_side (pos1)
  );

  msdig_div #(.NW(PW), .DW(DW), .SW(PW + DW)) u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v1),
    .in_num   (q1),
    .den      (rows_r),
    .in_side  ({pos1, n1}),
    .out_valid(v2),
    .out_quo  (batch2),
    .out_rem  (m2),
    .out_side ({pos2, n2})
  );

  // P1: diagonal offset and band test
  logic                 p1_vld_r, p1_inb_r;
  logic [PW-1:0]        p1_pos_r;
  logic [IW-1:0]        p1_batch_r;
  logic signed [BW-1:0] p1_n_r, p1_d_r;
  logic signed [BW-1:0] n_s, m_s, d_s;

  assign n_s = signed'(BW'(n2));
  assign m_s = signed'(BW'(m2));
  assign d_s = n_s - m_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= v2;
    end
    p1_inb_r   <= (k0_s <= d_s) && (d_s <= k1_s);
    p1_pos_r   <= pos2;
    p1_batch_r <= batch2[IW-1:0];
    p1_n_r     <= n_s;
    p1_d_r     <= d_s;
  end

  // P2: diagonal length and alignment
  logic                 p2_vld_r, p2_inb_r, p2_right_r;
  logic [PW-1:0]        p2_pos_r;
  logic [IW-1:0]        p2_batch_r;
  logic signed [BW-1:0] p2_len_r, p2_tdiff_r, p2_nsh_r, p2_nsgl_r;
  logic signed [BW-1:0] dpos_s, dneg_s, len_a, len_b;
  logic                 right_s;

  assign dpos_s  = (p1_d_r > 0) ? p1_d_r : '0;
  assign dneg_s  = (p1_d_r < 0) ? p1_d_r : '0;
  assign len_a   = nn_s - dpos_s;
  assign len_b   = mm_s + dneg_s;
  assign right_s = ((align_r == msdig_pkg::ALIGN_RL || align_r == msdig_pkg::ALIGN_RR) &&
                    p1_d_r >= 0) ||
                   ((align_r == msdig_pkg::ALIGN_LR || align_r == msdig_pkg::ALIGN_RR) &&
                    p1_d_r <= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_inb_r   <= p1_inb_r;
    p2_right_r <= right_s;
    p2_pos_r   <= p1_pos_r;
    p2_batch_r <= p1_batch_r;
    p2_len_r   <= (len_a < len_b) ? len_a : len_b;
    p2_tdiff_r <= k1_s - p1_d_r;
    p2_nsh_r   <= p1_n_r - dpos_s;
    p2_nsgl_r  <= p1_n_r - k1p_r;
  end

  // P3: padding and first products
  logic                 p3_vld_r, p3_inb_r;
  logic [PW-1:0]        p3_pos_r;
  logic [IW-1:0]        p3_bm_r, p3_tm_r, p3_nsgl_r;
  logic signed [BW-1:0] p3_indiag_r;
  logic signed [BW-1:0] off_s;

  assign off_s = p2_right_r ? (mdl_r - p2_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
    p3_inb_r    <= p2_inb_r;
    p3_pos_r    <= p2_pos_r;
    p3_indiag_r <= p2_nsh_r + off_s;
    p3_bm_r     <= IW'(p2_batch_r * to_iw(mdl_r));
    p3_tm_r     <= IW'(to_iw(p2_tdiff_r) * to_iw(mdl_r));
    p3_nsgl_r   <= to_iw(p2_nsgl_r);
  end

  // P4: batch stride and partial sums
  logic          p4_vld_r, p4_inb_r;
  logic [PW-1:0] p4_pos_r;
  logic [IW-1:0] p4_bnm_r, p4_sgl_r, p4_rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else begin
      p4_vld_r <= p3_vld_r;
    end
    p4_inb_r  <= p3_inb_r;
    p4_pos_r  <= p3_pos_r;
    p4_bnm_r  <= IW'(p3_bm_r * to_iw(nd_r));
    p4_sgl_r  <= IW'(p3_bm_r + p3_nsgl_r);
    p4_rest_r <= IW'(p3_tm_r + to_iw(p3_indiag_r));
  end

  // P5: source select, output register
  logic              out_strobe_r;
  logic [PW-1:0]     out_wi_r;
  msdig_pkg::src_t   out_src_r, src_nxt;
  logic [31:0]       out_sidx_r;
  logic [IW-1:0]     idx_s;

  assign idx_s = single_r ? p4_sgl_r : IW'(p4_bnm_r + p4_rest_r);

  always_comb begin
    if (p4_inb_r) begin
      src_nxt = present_r ? msdig_pkg::SRC_DIAG : msdig_pkg::SRC_ZERO;
    end else begin
      case (fill_r)
        msdig_pkg::FILL_INPUT: src_nxt = msdig_pkg::SRC_INPUT;
        msdig_pkg::FILL_BCAST: src_nxt = msdig_pkg::SRC_BCAST;
        default:               src_nxt = msdig_pkg::SRC_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= p4_vld_r;
    end
    out_wi_r   <= p4_pos_r;
    out_src_r  <= src_nxt;
    out_sidx_r <= (p4_inb_r && present_r) ? 32'(idx_s) : '0;
  end

  assign out_strobe       = out_strobe_r;
  assign out_write_index  = out_wi_r;
  assign out_source       = out_src_r;
  assign out_source_index = out_sidx_r;

endmodule

// File: hw/rtl/msdig_div.sv
// ----------------------------------------------------------------------------
// msdig_div: pipelined restoring divider, NW stages, one quotient bit each.
// A sideband word and a valid bit travel with each beat. The user must hold
// the divisor static while beats are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module msdig_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  logic [NW-1:0] vld_r;
  logic [DW-1:0] rem_r  [0:NW-1];
  logic [NW-1:0] dq_r   [0:NW-1];
  logic [SW-1:0] side_r [0:NW-1];

  genvar k;
  for (k = 0; k < NW; k++) begin : g_stg
    logic          vld_i;
    logic [DW-1:0] rem_i;
    logic [NW-1:0] dq_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   cand;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = '0;
      assign dq_i   = in_num;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign dq_i   = dq_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign cand = {rem_i, dq_i[NW-1]};
    assign ge   = (cand >= {1'b0, den});
    assign diff = cand - {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
      rem_r[k]  <= ge ? diff[DW-1:0] : cand[DW-1:0];
      dq_r[k]   <= {dq_i[NW-2:0], ge};
      side_r[k] <= side_i;
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quo   = dq_r[NW-1];
  assign out_rem   = rem_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

// File: hw/rtl/msdig_chk.sv
// ----------------------------------------------------------------------------
// msdig_chk: port-level checks for the index generator
// Latency, ordering and source index rules seen on the top level ports.
// ----------------------------------------------------------------------------
module msdig_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_position,
  input logic        out_strobe,
  input logic [31:0] out_write_index,
  input logic [1:0]  out_source,
  input logic [31:0] out_source_index
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result beat right after reset");

  a_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, msdig_pkg::PIPE_LAT))
    else $error("result beat without a matching input beat");

  a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_write_index == $past(in_position, msdig_pkg::PIPE_LAT))
    else $error("write index does not match the accepted position");

  a_sidx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_source != msdig_pkg::SRC_DIAG) |-> out_source_index == '0)
    else $error("source index set for a non-diagonal source");

endmodule

bind matrix_set_diag_index_gen_top msdig_chk u_msdig_chk (.*);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: diagonal band index generator testbench
// Drives element positions through the command port and programs the band
// and shape registers over the APB-style port. A local predictor computes
// source and diagonal index per accepted beat. Results are checked in order
// against the predicted queue. Directed tests come first, then randomized
// phases with varied sender idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          LIMIT_CYCLES = 400000;
  localparam int          MAX_REPORTS  = 100;
  localparam int          RAND_PHASES  = 24;
  localparam int          PHASE_BEATS  = 75;
  localparam logic [1:0]  FILL_ZERO    = 2'd2;
  localparam logic [1:0]  FILL_RSVD    = 2'd3;
  localparam logic [1:0]  ALIGN_LL     = 2'd2;

  typedef struct packed {
    logic [31:0]     write_index;
    msdig_pkg::src_t source;
    logic [31:0]     source_index;
  } index_beat_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [msdig_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         start = 1'b0;
  logic                         busy;
  logic [31:0]                  in_position = '0;
  logic                         out_strobe;
  logic [31:0]                  out_write_index;
  logic [1:0]                   out_source;
  logic [31:0]                  out_source_index;

  // local copy of the register file
  logic signed [16:0] band_lo = '0;
  logic signed [16:0] band_hi = '0;
  logic [15:0]        mat_rows = 16'd1;
  logic [15:0]        mat_cols = 16'd1;
  logic [31:0]        elem_count = '0;
  logic [1:0]         fill_sel = msdig_pkg::FILL_INPUT;
  logic               diag_present = 1'b1;
  logic [1:0]         align_sel = msdig_pkg::ALIGN_LR;

  index_beat_t pending_index_q[$];
  index_beat_t head_beat;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  matrix_set_diag_index_gen_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_position      (in_position),
    .out_strobe       (out_strobe),
    .out_write_index  (out_write_index),
    .out_source       (out_source),
    .out_source_index (out_source_index)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results pending", $time, pending_index_q.size());
      $display("[matrix_set_diag_index_gen_top] ERROR");
      $finish;
    end
  end

  function automatic longint lmin(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  // source and diagonal index of one position; 0 when no result is due
  function automatic bit predict_index(input logic [31:0] pos, output index_beat_t res);
    longint p, m_rows, n_cols, batch, row, col, d, k0, k1, mdl, nd, off, idx;
    bit     right_aligned;
    res.write_index  = pos;
    res.source       = msdig_pkg::SRC_ZERO;
    res.source_index = '0;
    if (pos >= elem_count || mat_rows == 0 || mat_cols == 0) return 1'b0;
    p      = {32'd0, pos};
    m_rows = {48'd0, mat_rows};
    n_cols = {48'd0, mat_cols};
    k0     = band_lo;
    k1     = band_hi;
    batch  = p / (m_rows * n_cols);
    row    = (p / n_cols) % m_rows;
    col    = p % n_cols;
    d      = col - row;
    if (k0 <= d && d <= k1) begin
      if (diag_present) begin
        mdl = lmin(m_rows + lmin(k1, 0), n_cols - lmax(k0, 0));
        if (k0 == k1) begin
          idx = batch * mdl + col - lmax(k1, 0);
        end else begin
          nd = k1 - k0 + 1;
          right_aligned = ((align_sel == msdig_pkg::ALIGN_RL ||
                            align_sel == msdig_pkg::ALIGN_RR) && d >= 0) ||
                          ((align_sel == msdig_pkg::ALIGN_LR ||
                            align_sel == msdig_pkg::ALIGN_RR) && d <= 0);
          off = right_aligned ? mdl - lmin(n_cols - lmax(d, 0), m_rows + lmin(d, 0)) : 0;
          idx = batch * nd * mdl + (k1 - d) * mdl + col - lmax(d, 0) + off;
        end
        res.source       = msdig_pkg::SRC_DIAG;
        res.source_index = idx[31:0];
      end else begin
        res.source = msdig_pkg::SRC_ZERO;
      end
    end else begin
      case (fill_sel)
        msdig_pkg::FILL_INPUT: res.source = msdig_pkg::SRC_INPUT;
        msdig_pkg::FILL_BCAST: res.source = msdig_pkg::SRC_BCAST;
        default:               res.source = msdig_pkg::SRC_ZERO;
      endcase
    end
    return 1'b1;
  endfunction

  task automatic report_field(input string fname, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch at position %h: expected %h, got %h",
                 $time, fname, head_beat.write_index, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_index_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, got index %h source %0d sidx %h",
                   $time, out_write_index, out_source, out_source_index);
      end else begin
        head_beat = pending_index_q.pop_front();
        report_field("write_index", head_beat.write_index, out_write_index);
        report_field("source", {30'd0, head_beat.source}, {30'd0, out_source});
        report_field("source_index", head_beat.source_index, out_source_index);
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      msdig_pkg::REG_LOWEST:  band_lo      = val[16:0];
      msdig_pkg::REG_HIGHEST: band_hi      = val[16:0];
      msdig_pkg::REG_ROWS:    mat_rows     = val[15:0];
      msdig_pkg::REG_COLS:    mat_cols     = val[15:0];
      msdig_pkg::REG_COUNT:   elem_count   = val;
      msdig_pkg::REG_FILL:    fill_sel     = val[1:0];
      msdig_pkg::REG_PRESENT: diag_present = val[0];
      default:                align_sel    = val[1:0];
    endcase
  endtask

  // stop sending, let every result and any result-less beat drain
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_index_q.size() != 0) @(posedge clk);
    repeat (msdig_pkg::PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic set_config(input int lo, input int hi, input int rows, input int cols,
                            input logic [31:0] count, input logic [1:0] fill,
                            input logic present, input logic [1:0] align);
    wait_idle();
    reg_write(msdig_pkg::REG_LOWEST, lo);
    reg_write(msdig_pkg::REG_HIGHEST, hi);
    reg_write(msdig_pkg::REG_ROWS, rows);
    reg_write(msdig_pkg::REG_COLS, cols);
    reg_write(msdig_pkg::REG_COUNT, count);
    reg_write(msdig_pkg::REG_FILL, {30'd0, fill});
    reg_write(msdig_pkg::REG_PRESENT, {31'd0, present});
    reg_write(msdig_pkg::REG_ALIGN, {30'd0, align});
  endtask

  task automatic send_position(input logic [31:0] pos);
    index_beat_t beat;
    start       <= 1'b1;
    in_position <= pos;
    do @(posedge clk); while (busy);
    if (predict_index(pos, beat)) pending_index_q.push_back(beat);
  endtask

  // each following cycle is idle with probability pct percent
  task automatic maybe_idle(input int pct);
    while (pct > 0 && $urandom_range(99, 0) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic test_reset_state();
    send_position(32'd0);
    send_position(32'hFFFF_FFFF);
    wait_idle();
    reg_write(msdig_pkg::REG_COUNT, 32'd2);
    send_position(32'd0);
    send_position(32'd1);
  endtask

  task automatic test_band_alignment();
    logic [1:0] align;
    for (int a = 0; a < 4; a++) begin
      align = a[1:0];
      set_config(-2, 1, 4, 5, 32'd40, msdig_pkg::FILL_INPUT, 1'b1, align);
      send_position(32'd5);
      send_position(32'd33);
    end
  endtask

  task automatic test_fill_modes();
    set_config(0, 0, 3, 3, 32'd18, msdig_pkg::FILL_INPUT, 1'b1, ALIGN_LL);
    send_position(32'd13);
    send_position(32'd1);
    set_config(0, 0, 3, 3, 32'd18, msdig_pkg::FILL_BCAST, 1'b1, ALIGN_LL);
    send_position(32'd1);
    set_config(0, 0, 3, 3, 32'd18, FILL_ZERO, 1'b1, ALIGN_LL);
    send_position(32'd1);
    set_config(0, 0, 3, 3, 32'd18, FILL_RSVD, 1'b1, ALIGN_LL);
    send_position(32'd1);
  endtask

  task automatic test_special_cases();
    set_config(-1, 1, 3, 3, 32'd9, msdig_pkg::FILL_BCAST, 1'b0, msdig_pkg::ALIGN_RR);
    send_position(32'd4);
    set_config(1, -1, 3, 3, 32'd9, msdig_pkg::FILL_BCAST, 1'b1, msdig_pkg::ALIGN_RR);
    send_position(32'd4);
    set_config(0, 0, 0, 3, 32'd9, msdig_pkg::FILL_INPUT, 1'b1, msdig_pkg::ALIGN_LR);
    send_position(32'd2);
    set_config(0, 0, 3, 0, 32'd9, msdig_pkg::FILL_INPUT, 1'b1, msdig_pkg::ALIGN_LR);
    send_position(32'd2);
    set_config(-65535, 65535, 65535, 65535, 32'hFFFF_FFFF, msdig_pkg::FILL_INPUT, 1'b1,
               msdig_pkg::ALIGN_RR);
    send_position(32'd0);
    send_position(32'hFFFF_FFFE);
    send_position(32'hFFFF_FFFF);
  endtask

  task automatic test_random_phases();
    int          r, c, lo, hi, span, tmp, idle_pct;
    longint      cnt;
    logic [31:0] count, pos;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(19, 0))
        0:       r = 0;
        1:       r = 65535;
        2, 3:    r = $urandom_range(65535, 1);
        default: r = $urandom_range(8, 1);
      endcase
      case ($urandom_range(19, 0))
        0:       c = 0;
        1:       c = 65535;
        2, 3:    c = $urandom_range(65535, 1);
        default: c = $urandom_range(8, 1);
      endcase
      span = r + c + 2;
      lo = int'($urandom_range(span, 0)) - r - 1;
      hi = int'($urandom_range(span, 0)) - r - 1;
      lo = (lo < -65535) ? -65535 : ((lo > 65535) ? 65535 : lo);
      hi = (hi < -65535) ? -65535 : ((hi > 65535) ? 65535 : hi);
      case ($urandom_range(9, 0))
        0: begin
          // empty band, or a single diagonal when lo equals hi
          if (lo < hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
        1: hi = lo;
        2: begin
          lo = -65535;
          hi = 65535;
        end
        default: begin
          if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
        end
      endcase
      cnt = longint'(r) * longint'(c) * longint'($urandom_range(6, 1));
      case ($urandom_range(9, 0))
        0:       count = $urandom;
        1:       count = 32'hFFFF_FFFF;
        default: count = (cnt == 0) ? $urandom : ((cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                          : cnt[31:0]);
      endcase
      set_config(lo, hi, r, c, count, 2'($urandom_range(3, 0)),
                 ($urandom_range(9, 0) != 0), 2'($urandom_range(3, 0)));
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 47;
        default: idle_pct = 28;
      endcase
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (count == 0 || $urandom_range(99, 0) < 15) pos = $urandom;
        else pos = $urandom_range(count - 1, 0);
        send_position(pos);
        maybe_idle(idle_pct);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_band_alignment();
    test_fill_modes();
    test_special_cases();
    test_random_phases();
    wait_idle();
    if (mismatch_count == 0 && pending_index_q.size() == 0) begin
      $display("[matrix_set_diag_index_gen_top] OK");
    end else begin
      $display("[matrix_set_diag_index_gen_top] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/msdig_pkg.sv
hw/rtl/msdig_div.sv
hw/rtl/matrix_set_diag_index_gen_top.sv
hw/rtl/msdig_chk.sv
test/tb_top.sv
